[hw/rtl/key_long_press_repeat_tracker_defines.svh]
// Assertion macros for the key long-press tracker.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef KEY_LONG_PRESS_REPEAT_TRACKER_DEFINES_SVH
`define KEY_LONG_PRESS_REPEAT_TRACKER_DEFINES_SVH
`ifndef SYNTHESIS
`define KLPRT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define KLPRT_ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define KLPRT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define KLPRT_ASSERT_NEXT(label, clk, ante, cons)
`endif
`endif

[hw/rtl/klprt_pkg.sv]
// Shared types and constants for the key long-press tracker.
// No dependencies.
package klprt_pkg;

    localparam int KEY_IDX_W  = 3;
    localparam int CNT_W      = 16;
    localparam int MASK_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WAIT   = 2'd0,
        CFG_REPEAT = 2'd1,
        CFG_MASK   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [KEY_IDX_W-1:0] key_index;
        logic                 level;
    } t_in_item;

    typedef struct packed {
        logic [KEY_IDX_W-1:0] key_number;
        logic                 is_pressed;
        logic                 is_released;
        logic                 press_edge;
        logic                 release_edge;
        logic                 long_release_edge;
        logic                 long_press_event;
        logic                 repeat_event;
    } t_out_item;

    typedef struct packed {
        logic             prev_level;
        logic             long_flag;
        logic [CNT_W-1:0] countdown;
    } t_key_entry;

endpackage

[hw/rtl/klprt_state_mem.sv]
// Per-key state memory: one write port, one registered read port, write-first
// on a same-address collision, per-entry valid bits so unwritten entries read zero.
// Depends on klprt_pkg.
module klprt_state_mem #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_we,
    input  logic [ADDR_W-1:0]      i_waddr,
    input  klprt_pkg::t_key_entry  i_wdata,
    input  logic                   i_re,
    input  logic [ADDR_W-1:0]      i_raddr,
    output klprt_pkg::t_key_entry  o_rdata
);
    import klprt_pkg::*;

    t_key_entry       mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    t_key_entry       r_rd_raw;
    t_key_entry       r_byp_data;
    logic             r_rd_byp;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd_raw   <= mem[i_raddr];
            r_byp_data <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_byp <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_byp <= i_we && (i_waddr == i_raddr);
                r_rd_vld <= r_vld[i_raddr];
            end
        end
    end

    always_comb begin
        if (r_rd_byp) begin
            o_rdata = r_byp_data;
        end else if (r_rd_vld) begin
            o_rdata = r_rd_raw;
        end else begin
            o_rdata = '0;
        end
    end

endmodule

[hw/rtl/klprt_update.sv]
// Per-key edge / hold countdown update: next state entry and result flags.
// Depends on klprt_pkg.
module klprt_update (
    input  klprt_pkg::t_key_entry                i_entry,
    input  logic [klprt_pkg::KEY_IDX_W-1:0]      i_key,
    input  logic                                 i_level,
    input  logic [klprt_pkg::CNT_W-1:0]          i_wait_ticks,
    input  logic [klprt_pkg::CNT_W-1:0]          i_repeat_ticks,
    output klprt_pkg::t_key_entry                o_entry,
    output klprt_pkg::t_out_item                 o_result
);
    import klprt_pkg::*;

    logic rise;
    logic fall;
    logic held;
    logic cnt_zero;

    assign rise     = i_level && !i_entry.prev_level;
    assign fall     = !i_level && i_entry.prev_level;
    assign held     = i_level && i_entry.prev_level;
    assign cnt_zero = (i_entry.countdown == '0);

    always_comb begin
        o_entry            = i_entry;
        o_entry.prev_level = i_level;
        priority if (rise || fall) begin
            o_entry.countdown = i_wait_ticks;
            o_entry.long_flag = 1'b0;
        end else if (held && cnt_zero) begin
            o_entry.countdown = i_repeat_ticks;
            o_entry.long_flag = 1'b1;
        end else if (held) begin
            o_entry.countdown = i_entry.countdown - CNT_W'(1);
        end else begin
            o_entry.countdown = i_entry.countdown;
        end
    end

    always_comb begin
        o_result.key_number        = i_key;
        o_result.is_pressed        = i_level;
        o_result.is_released       = !i_level;
        o_result.press_edge        = rise;
        o_result.release_edge      = fall && !i_entry.long_flag;
        o_result.long_release_edge = fall && i_entry.long_flag;
        o_result.long_press_event  = held && cnt_zero && !i_entry.long_flag;
        o_result.repeat_event      = held && cnt_zero && i_entry.long_flag;
    end

endmodule

[hw/rtl/key_long_press_repeat_tracker.sv]
// Key long-press / auto-repeat tracker, top level.
// Depends on klprt_pkg, klprt_state_mem, klprt_update and the defines header.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) carries one sample per
// transfer: key index and level. Samples of disabled keys, or of keys at or
// beyond KEY_COUNT, are accepted and dropped without a result.
// Output channel (o_out_valid / i_out_stall / o_out_data) gives one result per
// tracked sample, in sample order.
// An accepted sample moves through stage s1 and then the output register.
// Throughput: one sample per cycle while the output is not stalled; per-key
// state sits in a memory read in the accept cycle and written back as the
// sample leaves s1, with a write-first bypass for back-to-back samples of the same key.
// Configuration: i_cfg_we / i_cfg_index / i_cfg_data write wait, repeat and
// enable mask; write only while the block is idle.
// Reset: registers clear, key state reads as zero through per-entry valid
// bits, no clearing pass. A stalled output holds its result, the stage in
// front holds one more, and the input stalls after that.
`include "key_long_press_repeat_tracker_defines.svh"
module key_long_press_repeat_tracker #(
    parameter int KEY_COUNT = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [klprt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [klprt_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  klprt_pkg::t_in_item                  i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output klprt_pkg::t_out_item                 o_out_data
);
    import klprt_pkg::*;

    localparam int ADDR_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

    logic [CNT_W-1:0]     r_wait_ticks;
    logic [CNT_W-1:0]     r_repeat_ticks;
    logic [MASK_W-1:0]    r_key_mask;

    logic                 r_s1_vld;
    logic [ADDR_W-1:0]    r_s1_addr;
    logic [KEY_IDX_W-1:0] r_s1_key;
    logic                 r_s1_level;

    logic                 r_out_vld;
    t_out_item            r_out_data;

    logic                 in_acc;
    logic                 s1_adv;
    logic                 key_en;
    logic [6:0]           idx_ext;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 mem_we;
    t_key_entry           rd_entry;
    t_key_entry           nx_entry;
    t_out_item            nx_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_ticks   <= '0;
            r_repeat_ticks <= '0;
            r_key_mask     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WAIT:   r_wait_ticks   <= i_cfg_data[CNT_W-1:0];
                CFG_REPEAT: r_repeat_ticks <= i_cfg_data[CNT_W-1:0];
                CFG_MASK:   r_key_mask     <= i_cfg_data[MASK_W-1:0];
                default:    ;
            endcase
        end
    end

    assign s1_adv     = !r_out_vld || !i_out_stall;
    assign o_in_stall = r_s1_vld && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign idx_ext    = 7'(i_in_data.key_index);
    assign rd_addr    = idx_ext[ADDR_W-1:0];
    assign key_en     = (idx_ext < 7'(KEY_COUNT)) && r_key_mask[i_in_data.key_index];
    assign mem_we     = r_s1_vld && s1_adv;

    klprt_state_mem #(
        .DEPTH  (KEY_COUNT),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (r_s1_addr),
        .i_wdata (nx_entry),
        .i_re    (in_acc),
        .i_raddr (rd_addr),
        .o_rdata (rd_entry)
    );

    klprt_update u_update (
        .i_entry        (rd_entry),
        .i_key          (r_s1_key),
        .i_level        (r_s1_level),
        .i_wait_ticks   (r_wait_ticks),
        .i_repeat_ticks (r_repeat_ticks),
        .o_entry        (nx_entry),
        .o_result       (nx_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (!r_s1_vld || s1_adv) begin
                r_s1_vld <= in_acc && key_en;
            end
            if (s1_adv) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_addr  <= rd_addr;
            r_s1_key   <= i_in_data.key_index;
            r_s1_level <= i_in_data.level;
        end
        if (mem_we) begin
            r_out_data <= nx_result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

    `KLPRT_ASSERT_IMPL(a_stall_needs_full_stage, i_clk, i_rst_n, o_in_stall, r_s1_vld && r_out_vld)
    `KLPRT_ASSERT_IMPL(a_events_exclusive, i_clk, i_rst_n, r_out_vld, $onehot0({r_out_data.press_edge, r_out_data.release_edge, r_out_data.long_release_edge, r_out_data.long_press_event, r_out_data.repeat_event}))
    `KLPRT_ASSERT_IMPL(a_level_flags, i_clk, i_rst_n, r_out_vld, r_out_data.is_pressed != r_out_data.is_released)
    `KLPRT_ASSERT_IMPL(a_high_events_pressed, i_clk, i_rst_n, r_out_vld && (r_out_data.press_edge || r_out_data.long_press_event || r_out_data.repeat_event), r_out_data.is_pressed)
    `KLPRT_ASSERT_NEXT(a_reset_empties, i_clk, !i_rst_n, !r_out_vld && !r_s1_vld)

endmodule

[dv/key_long_press_repeat_tracker_tb.sv]
// Self-checking testbench for key_long_press_repeat_tracker: directed and random key samples,
// per-key prediction of press/release/long-press/repeat events, random input gaps, output stalls.
// Depends on klprt_pkg and the tracker RTL.
module key_long_press_repeat_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import klprt_pkg::*;

    localparam int KEYS          = 8;
    localparam int LIMIT_CYCLES  = 500000;
    localparam int HOLD_CYCLES   = 100;
    localparam int DRAIN_CYCLES  = 4;
    localparam int PHASE_SAMPLES = 120;
    localparam int RANDOM_TARGET = 800;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;

    // predictor state
    logic [CNT_W-1:0]  wait_val    = '0;
    logic [CNT_W-1:0]  repeat_val  = '0;
    logic [MASK_W-1:0] enable_mask = '0;
    logic              prev_lvl[KEYS];
    logic [CNT_W-1:0]  hold_cnt[KEYS];
    logic              lp_flag[KEYS];

    t_out_item expected_events[$];
    t_out_item head_event;
    int        mismatches      = 0;
    int        tracked_samples = 0;
    int        cycle_count     = 0;
    int        hold_plan[KEYS];
    bit        hold_request    = 0;
    bit        hold_active     = 0;
    bit        burst_mode      = 0;

    key_long_press_repeat_tracker #(.KEY_COUNT(KEYS)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        for (int k = 0; k < KEYS; k++) begin
            prev_lvl[k]  = 1'b0;
            hold_cnt[k]  = '0;
            lp_flag[k]   = 1'b0;
            hold_plan[k] = 0;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic track_sample(input t_in_item s);
        t_out_item ev;
        logic [KEY_IDX_W-1:0] k;
        k = s.key_index;
        if (!enable_mask[k]) return;
        ev = '0;
        ev.key_number  = k;
        ev.is_pressed  = s.level;
        ev.is_released = !s.level;
        if (s.level && !prev_lvl[k]) begin
            ev.press_edge = 1'b1;
            hold_cnt[k]   = wait_val;
            lp_flag[k]    = 1'b0;
        end else if (!s.level && prev_lvl[k]) begin
            if (lp_flag[k]) ev.long_release_edge = 1'b1;
            else ev.release_edge = 1'b1;
            hold_cnt[k] = wait_val;
            lp_flag[k]  = 1'b0;
        end else if (s.level) begin
            if (hold_cnt[k] == '0) begin
                if (lp_flag[k]) begin
                    ev.repeat_event = 1'b1;
                end else begin
                    ev.long_press_event = 1'b1;
                    lp_flag[k] = 1'b1;
                end
                hold_cnt[k] = repeat_val;
            end else begin
                hold_cnt[k] = hold_cnt[k] - 1'b1;
            end
        end
        prev_lvl[k] = s.level;
        tracked_samples++;
        expected_events.push_back(ev);
    endtask

    task automatic check_field(input string name, input logic [2:0] exp_v,
                               input logic [2:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // sample both channels where all signals are settled; a transfer completes at the next edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid !== 1'b0 && i_out_stall == 1'b0) begin
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected result expected none actual %h", $time, o_out_data);
                    mismatches++;
                end else begin
                    head_event = expected_events.pop_front();
                    check_field("key_number", head_event.key_number, o_out_data.key_number);
                    check_field("is_pressed", head_event.is_pressed, o_out_data.is_pressed);
                    check_field("is_released", head_event.is_released, o_out_data.is_released);
                    check_field("press_edge", head_event.press_edge, o_out_data.press_edge);
                    check_field("release_edge", head_event.release_edge,
                                o_out_data.release_edge);
                    check_field("long_release_edge", head_event.long_release_edge,
                                o_out_data.long_release_edge);
                    check_field("long_press_event", head_event.long_press_event,
                                o_out_data.long_press_event);
                    check_field("repeat_event", head_event.repeat_event,
                                o_out_data.repeat_event);
                end
            end
            if (i_in_valid && o_in_stall === 1'b0) track_sample(i_in_data);
        end
    end

    initial begin : out_stall_gen
        int r;
        int n;
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_active = 1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 0;
                hold_active  = 0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    i_out_stall <= 1'b0;
                    n = $urandom_range(40, 80);
                end else begin
                    n = pick_gap();
                    i_out_stall <= (n != 0);
                    if (n == 0) n = 1;
                end
                repeat (n) @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("key_long_press_repeat_tracker_tb NOT OK");
        $finish;
    end

    // entered and left at a rising edge
    task automatic send_sample(input logic [KEY_IDX_W-1:0] k, input logic lvl);
        t_in_item s;
        bit took;
        int gap;
        s.key_index = k;
        s.level     = lvl;
        i_in_valid <= 1'b1;
        i_in_data  <= s;
        do begin
            @(negedge i_clk);
            took = (o_in_stall === 1'b0);
            @(posedge i_clk);
        end while (!took);
        gap = burst_mode ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_WAIT:   wait_val    = val;
            CFG_REPEAT: repeat_val  = val;
            CFG_MASK:   enable_mask = val[MASK_W-1:0];
            default:    ;
        endcase
    endtask

    task automatic configure(input logic [CNT_W-1:0] w, input logic [CNT_W-1:0] r,
                             input logic [MASK_W-1:0] m);
        write_reg(CFG_WAIT, w);
        write_reg(CFG_REPEAT, r);
        write_reg(CFG_MASK, {{(CFG_DATA_W-MASK_W){1'b0}}, m});
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // mostly press-hold-release runs per key, with some random levels mixed in
    task automatic send_random_sample();
        logic [KEY_IDX_W-1:0] k;
        logic lvl;
        k = KEY_IDX_W'($urandom_range(0, KEYS-1));
        repeat (3) if (!enable_mask[k]) k = KEY_IDX_W'($urandom_range(0, KEYS-1));
        if ($urandom_range(0, 9) == 0) begin
            lvl = 1'($urandom_range(0, 1));
        end else if (hold_plan[k] > 0) begin
            lvl = 1'b1;
            hold_plan[k]--;
        end else begin
            lvl = 1'b0;
            if ($urandom_range(0, 2) == 0) hold_plan[k] = $urandom_range(1, 12);
        end
        send_sample(k, lvl);
    endtask

    task automatic test_reset_state();
        for (int k = 0; k < KEYS; k++) send_sample(KEY_IDX_W'(k), 1'b1);
        send_sample(3'd0, 1'b0);
        wait_idle();
    endtask

    task automatic test_edges_and_long_press();
        configure(16'd2, 16'd1, 8'hFF);
        send_sample(3'd0, 1'b0);
        repeat (6) send_sample(3'd0, 1'b1);
        send_sample(3'd0, 1'b0);
        send_sample(3'd7, 1'b1);
        send_sample(3'd7, 1'b0);
        wait_idle();
    endtask

    task automatic test_zero_repeat();
        configure(16'd0, 16'd0, 8'hFF);
        repeat (4) send_sample(3'd3, 1'b1);
        send_sample(3'd3, 1'b0);
        wait_idle();
    endtask

    task automatic test_disabled_key();
        write_reg(CFG_MASK, 16'h007F);
        send_sample(3'd7, 1'b1);
        wait_idle();
        write_reg(CFG_MASK, 16'h00FF);
        send_sample(3'd7, 1'b0);
        wait_idle();
    endtask

    task automatic test_extreme_counts();
        configure(16'hFFFF, 16'hFFFF, 8'hFF);
        send_sample(3'd5, 1'b1);
        send_sample(3'd5, 1'b1);
        send_sample(3'd5, 1'b0);
        wait_idle();
        write_reg(CFG_UNUSED, 16'h0000);
        send_sample(3'd5, 1'b1);
        send_sample(3'd5, 1'b0);
        wait_idle();
    endtask

    task automatic test_output_hold_off();
        configure(16'd1, 16'd0, 8'hFF);
        hold_request = 1;
        wait (hold_active);
        @(posedge i_clk);
        burst_mode = 1;
        repeat (40) send_random_sample();
        burst_mode = 0;
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int base;
        int phase;
        logic [CNT_W-1:0] w;
        logic [CNT_W-1:0] r;
        logic [MASK_W-1:0] m;
        base  = tracked_samples;
        phase = 0;
        while (tracked_samples - base < RANDOM_TARGET) begin
            case (phase)
                0: begin w = '0;       r = '0;       m = 8'hFF; end
                1: begin w = 16'hFFFF; r = 16'hFFFF; m = 8'hFF; end
                2: begin w = '0;       r = 16'hFFFF; m = MASK_W'($urandom_range(1, 255)); end
                3: begin w = 16'hFFFF; r = '0;       m = 8'hFF; end
                default: begin
                    w = ($urandom_range(0, 7) == 0) ? CNT_W'($urandom_range(0, 65535))
                                                    : CNT_W'($urandom_range(0, 6));
                    r = CNT_W'($urandom_range(0, 4));
                    m = ($urandom_range(0, 3) == 0) ? 8'hFF
                                                    : MASK_W'($urandom_range(1, 255));
                end
            endcase
            configure(w, r, m);
            burst_mode = (phase % 3 == 2);
            repeat (PHASE_SAMPLES) send_random_sample();
            burst_mode = 0;
            wait_idle();
            phase++;
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_edges_and_long_press();
        test_zero_repeat();
        test_disabled_key();
        test_extreme_counts();
        test_output_hold_off();
        test_random_traffic();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_events.size() == 0) begin
            $display("key_long_press_repeat_tracker_tb OK");
        end else begin
            $display("key_long_press_repeat_tracker_tb NOT OK");
        end
        $finish;
    end

endmodule
